>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> hw/rtl/ebtn_dbnc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebtn_dbnc_pkg
// Shared types and constants of the exclusive button debouncer.
// ----------------------------------------------------------------------------
package ebtn_dbnc_pkg;

    // Classified sample codes from the ladder front end
    typedef enum logic [1:0] {
        KIND_UNKNOWN  = 2'd0,
        KIND_RELEASED = 2'd1,
        KIND_PRESSED  = 2'd2,
        KIND_INVALID  = 2'd3
    } sample_kind_t;

    // Field widths fixed by the interface
    localparam int KIND_BITS   = 2;
    localparam int PORT_ID_BITS = 8;
    localparam int CNT_BITS    = 4;

    // Threshold after reset
    localparam logic [CNT_BITS-1:0] CONFIRM_RESET = 4'd3;

endpackage

>>> hw/rtl/exclusive_button_debouncer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exclusive_button_debouncer_unit
// Debounces classified ladder samples into one exclusive stable button id.
// ----------------------------------------------------------------------------
//  channel | ports                                    | direction
//  --------+------------------------------------------+----------
//  input   | s_valid s_ready s_sample_kind s_button_id | in
//  result  | m_valid m_ready m_accepted m_stable_button | out
//  config  | cfg_valid cfg_ready cfg_data              | in
//
//  One transaction per cycle sustained while the result is not stalled; an
//  accepted input passes through the input register, then the result
//  register, before the result is offered on m_valid.
//  The debounce state updates as an item leaves the input register.
//  A stalled result holds the result register; the input register still
//  takes one more transaction before s_ready drops. Synchronous active-low
//  reset clears valid flags and debounce state; threshold resets to 3.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module exclusive_button_debouncer_unit
    import ebtn_dbnc_pkg::*;
#(
    parameter int ID_BITS = 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // configuration write
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CNT_BITS-1:0]     cfg_data,
    // sample input
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [KIND_BITS-1:0]    s_sample_kind,
    input  logic [PORT_ID_BITS-1:0] s_button_id,
    // result output
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_accepted,
    output logic [PORT_ID_BITS-1:0] m_stable_button
);

    // Configuration
    logic [CNT_BITS-1:0]     confirm_reg;

    // Input stage
    logic                    in_valid_reg;
    sample_kind_t            in_kind_reg;
    logic [PORT_ID_BITS-1:0] in_id_reg;

    // Debounce state
    logic [ID_BITS-1:0]      held_reg,        held_next;
    logic [ID_BITS-1:0]      pending_id_reg,  pending_id_next;
    logic [CNT_BITS-1:0]     pending_cnt_reg, pending_cnt_next;
    logic [CNT_BITS-1:0]     release_reg,     release_next;

    // Result stage
    logic                    out_valid_reg;
    logic                    out_accepted_reg;
    logic [PORT_ID_BITS-1:0] out_stable_reg;

    logic                    advance;
    logic                    sample_ok;
    logic [ID_BITS-1:0]      id_w;

    // Handshake: result stage frees when empty or drained
    assign advance   = !out_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Id kept in ID_BITS bits
    assign id_w = ID_BITS'(in_id_reg);

    // Sample validity check
    always_comb begin
        case (in_kind_reg)
            KIND_PRESSED: begin
                sample_ok = (id_w != '0);
            end
            KIND_UNKNOWN, KIND_RELEASED: begin
                sample_ok = (id_w == '0);
            end
            default: begin
                sample_ok = 1'b0;
            end
        endcase
    end

    // Debounce state update
    always_comb begin
        logic [CNT_BITS-1:0] run_w;
        logic [CNT_BITS-1:0] cnt_w;
        logic [ID_BITS-1:0]  pid_w;

        held_next        = held_reg;
        pending_id_next  = pending_id_reg;
        pending_cnt_next = pending_cnt_reg;
        release_next     = release_reg;
        run_w            = release_reg;
        cnt_w            = pending_cnt_reg;
        pid_w            = pending_id_reg;

        if (sample_ok) begin
            if (held_reg != '0) begin
                // a button is held: count released samples
                pending_id_next  = '0;
                pending_cnt_next = '0;
                if (in_kind_reg == KIND_RELEASED) begin
                    if (release_reg < confirm_reg) begin
                        run_w = release_reg + 1'b1;
                    end
                    if (run_w >= confirm_reg) begin
                        held_next    = '0;
                        release_next = '0;
                    end else begin
                        release_next = run_w;
                    end
                end else begin
                    release_next = '0;
                end
            end else begin
                // nothing held: qualify a candidate press
                release_next = '0;
                if (in_kind_reg != KIND_PRESSED) begin
                    pending_id_next  = '0;
                    pending_cnt_next = '0;
                end else begin
                    if (pending_id_reg != id_w) begin
                        pid_w = id_w;
                        cnt_w = CNT_BITS'(1);
                    end else if (pending_cnt_reg < confirm_reg) begin
                        cnt_w = pending_cnt_reg + 1'b1;
                    end
                    if (cnt_w >= confirm_reg) begin
                        held_next        = pid_w;
                        pending_id_next  = '0;
                        pending_cnt_next = '0;
                    end else begin
                        pending_id_next  = pid_w;
                        pending_cnt_next = cnt_w;
                    end
                end
            end
        end
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            confirm_reg <= CONFIRM_RESET;
        end else if (cfg_valid && cfg_ready) begin
            confirm_reg <= cfg_data;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg <= sample_kind_t'(s_sample_kind);
            in_id_reg   <= s_button_id;
        end
    end

    // State registers, updated as an item moves to the result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg        <= '0;
            pending_id_reg  <= '0;
            pending_cnt_reg <= '0;
            release_reg     <= '0;
        end else if (in_valid_reg && advance) begin
            held_reg        <= held_next;
            pending_id_reg  <= pending_id_next;
            pending_cnt_reg <= pending_cnt_next;
            release_reg     <= release_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid_reg && advance) begin
            out_accepted_reg <= sample_ok;
            out_stable_reg   <= PORT_ID_BITS'(held_next);
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_accepted      = out_accepted_reg;
    assign m_stable_button = out_stable_reg;

    // Checks
    `ASSERT_SAME(a_held_clears_pending, aclk, aresetn, held_reg != '0, pending_id_reg == '0 && pending_cnt_reg == '0)
    `ASSERT_SAME(a_idle_no_release_run, aclk, aresetn, held_reg == '0, release_reg == '0)
    `ASSERT_SAME(a_pending_pair, aclk, aresetn, 1'b1, (pending_id_reg == '0) == (pending_cnt_reg == '0))
    `ASSERT_NEXT(a_reject_keeps_held, aclk, aresetn, in_valid_reg && advance && !sample_ok, $stable(held_reg))

endmodule
